[src/nbs_pkg.sv]
// Shared types and constants for the USB NRZI bit-stuffing encoder.
// No dependencies; nbs_front, nbs_back and the top level import this package.
package nbs_pkg;

    localparam int STUFF_RUN_DEFAULT = 6;
    localparam int RUN_W             = 3;
    localparam int CNT_W             = 4;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE = 8'h80;

    typedef enum logic [1:0] {
        SYM_J   = 2'd0,
        SYM_K   = 2'd1,
        SYM_SE0 = 2'd2
    } nbs_sym_t;

    typedef struct packed {
        logic [7:0] data;
        logic       send_sync;
        logic       send_eop;
    } nbs_cmd_t;

endpackage

[src/nbs_in_if.sv]
// Input channel: packet bytes with first and last marks, valid/ready handshake.
// Depends on nothing.
interface nbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;

    modport source (output valid, output data_byte, output first_of_packet,
                    output last_of_packet, input ready);
    modport sink (input valid, input data_byte, input first_of_packet,
                  input last_of_packet, output ready);
endinterface

[src/nbs_out_if.sv]
// Output channel: one line symbol per item, valid/ready handshake.
// Depends on nothing.
interface nbs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_symbol;
    logic       end_of_run;

    modport source (output valid, output line_symbol, output end_of_run, input ready);
    modport sink (input valid, input line_symbol, input end_of_run, output ready);
endinterface

[src/nbs_front.sv]
// Front end: accepts input items, turns them into encoder commands and queues them.
// Depends on nbs_pkg and nbs_in_if.
module nbs_front
    import nbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    nbs_in_if.sink   bytes,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output nbs_cmd_t cmd
);

    nbs_cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic                  push;
    logic                  pop;
    nbs_cmd_t              new_cmd;

    assign bytes.ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push        = bytes.valid && bytes.ready;
    assign pop         = cmd_valid && cmd_ready;
    assign cmd_valid   = (count_reg != '0);
    assign cmd         = queue_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.data      = bytes.data_byte;
        new_cmd.send_sync = bytes.first_of_packet;
        new_cmd.send_eop  = bytes.last_of_packet;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

[src/nbs_back.sv]
// Back end: sequences sync, data bits, stuffed toggles and end of packet into an
// output register, one line symbol per cycle while the output is taken. Depends on nbs_pkg, nbs_out_if.
module nbs_back
    import nbs_pkg::*;
#(
    parameter int STUFF_RUN = STUFF_RUN_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  nbs_cmd_t cmd,
    nbs_out_if.source symbols
);

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_DATA,
        PH_EOP
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stuff_reg, stuff_next;
    logic             line_reg, line_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [1:0]       eop_cnt_reg, eop_cnt_next;
    logic [7:0]       data_reg, data_next;
    logic             eop_reg, eop_next;
    logic             out_valid_reg, out_valid_next;
    nbs_sym_t         sym_reg, sym_next;
    logic             eor_reg, eor_next;

    logic             advance;
    logic             load;
    logic             is_last;
    logic             cur_bit;
    logic             byte_done;
    nbs_sym_t         step_sym;
    logic             line_step;
    logic [RUN_W-1:0] run_step;
    logic [CNT_W-1:0] cnt_step;
    logic             stuff_step;

    assign advance   = busy_reg && (!out_valid_reg || symbols.ready);
    assign cmd_ready = !busy_reg || (advance && is_last);
    assign load      = cmd_valid && cmd_ready;
    assign cur_bit   = (phase_reg == PH_SYNC) ? SYNC_BYTE[cnt_reg[2:0]]
                                              : data_reg[cnt_reg[2:0]];

    assign symbols.valid       = out_valid_reg;
    assign symbols.line_symbol = sym_reg;
    assign symbols.end_of_run  = eor_reg;

    always_comb
    begin
        line_step    = line_reg;
        run_step     = run_reg;
        cnt_step     = cnt_reg;
        stuff_step   = 1'b0;
        byte_done    = 1'b0;
        is_last      = 1'b0;
        eop_cnt_next = eop_cnt_reg;
        if (phase_reg == PH_EOP)
        begin
            step_sym     = eop_cnt_reg[1] ? SYM_J : SYM_SE0;
            line_step    = 1'b0;
            run_step     = '0;
            eop_cnt_next = eop_cnt_reg + 1'b1;
            is_last      = (eop_cnt_reg == 2'd3);
        end
        else
        begin
            if (stuff_reg)
            begin
                line_step = ~line_reg;
                run_step  = '0;
            end
            else if (!cur_bit)
            begin
                line_step = ~line_reg;
                run_step  = '0;
                cnt_step  = cnt_reg + 1'b1;
            end
            else
            begin
                run_step = run_reg + 1'b1;
                cnt_step = cnt_reg + 1'b1;
            end
            stuff_step = (run_step == RUN_W'(STUFF_RUN));
            byte_done  = (cnt_step == CNT_W'(8)) && !stuff_step;
            is_last    = byte_done && (phase_reg == PH_DATA) && !eop_reg;
            step_sym   = line_step ? SYM_K : SYM_J;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        stuff_next     = stuff_reg;
        line_next      = line_reg;
        run_next       = run_reg;
        data_next      = data_reg;
        eop_next       = eop_reg;
        out_valid_next = out_valid_reg;
        sym_next       = sym_reg;
        eor_next       = eor_reg;

        if (advance)
        begin
            line_next      = line_step;
            run_next       = run_step;
            cnt_next       = cnt_step;
            stuff_next     = stuff_step;
            out_valid_next = 1'b1;
            sym_next       = step_sym;
            eor_next       = is_last;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            if (byte_done)
            begin
                cnt_next = '0;
                if (phase_reg == PH_SYNC)
                begin
                    phase_next = PH_DATA;
                end
                else
                begin
                    phase_next = PH_EOP;
                end
            end
        end
        else if (symbols.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            busy_next  = 1'b1;
            phase_next = cmd.send_sync ? PH_SYNC : PH_DATA;
            cnt_next   = '0;
            stuff_next = 1'b0;
            data_next  = cmd.data;
            eop_next   = cmd.send_eop;
            if (cmd.send_sync)
            begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            stuff_reg     <= 1'b0;
            line_reg      <= 1'b0;
            run_reg       <= '0;
            eop_cnt_reg   <= '0;
            data_reg      <= '0;
            eop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            sym_reg       <= SYM_J;
            eor_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            stuff_reg     <= stuff_next;
            line_reg      <= line_next;
            run_reg       <= run_next;
            eop_cnt_reg   <= (load || !advance) ? (load ? 2'd0 : eop_cnt_reg) : eop_cnt_next;
            data_reg      <= data_next;
            eop_reg       <= eop_next;
            out_valid_reg <= out_valid_next;
            sym_reg       <= sym_next;
            eor_reg       <= eor_next;
        end
    end

    a_stuff_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_reg |-> (run_reg == RUN_W'(STUFF_RUN)))
        else $error("stuff pending without a full run of ones");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= RUN_W'(STUFF_RUN))
        else $error("run count passed the stuffing threshold");

    a_no_sym3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sym_reg == SYM_J || sym_reg == SYM_K || sym_reg == SYM_SE0))
        else $error("illegal line symbol");

    a_eop_ends_at_j: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last && phase_reg == PH_EOP) |=> (line_reg == 1'b0 && run_reg == '0))
        else $error("end of packet left line away from J");

endmodule

[src/usb_nrzi_bit_stuff_encoder_top.sv]
// Top level of the USB full-speed NRZI bit-stuffing encoder.
// Depends on nbs_pkg, nbs_in_if, nbs_out_if, nbs_front and nbs_back.
//
// Each accepted byte produces one line symbol per output item: eight to ten
// for the byte (data bits plus stuffed toggles), eight more for the sync byte
// when first_of_packet is set, and four more (SE0, SE0, J, J) when
// last_of_packet is set; end_of_run marks the final symbol of each byte. The
// back-end sequencer emits one symbol per clock while the output is taken, and
// the next byte is loaded in the same cycle that its predecessor's last symbol
// is sequenced. A two-entry command queue and a registered output let the
// input and output sides stall independently; a byte accepted into an empty
// block passes the queue and back-end state before its first symbol appears.
module usb_nrzi_bit_stuff_encoder_top
    import nbs_pkg::*;
#(
    parameter int STUFF_RUN = STUFF_RUN_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    nbs_in_if.sink     bytes,
    nbs_out_if.source  symbols
);

    logic     cmd_valid;
    logic     cmd_ready;
    nbs_cmd_t cmd;

    nbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    nbs_back #(
        .STUFF_RUN (STUFF_RUN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .symbols   (symbols)
    );

endmodule
